/* rtl/core/spc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spc_pkg;

  // Default store depths; both are powers of two.
  localparam int SAMPLE_DEPTH_DEF  = 16384;
  localparam int OVERLAY_DEPTH_DEF = 64;

  // Midpoint of an offset-binary byte, gain shift (volume is in 1/64 steps)
  // and the longest loop that still counts as no loop.
  localparam int CENTRE     = 128;
  localparam int GAIN_SHIFT = 6;
  localparam int MIN_LOOP   = 2;

  localparam int OP_W    = 3;
  localparam int ADDR_W  = 14;
  localparam int BYTE_W  = 8;
  localparam int CUR_W   = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_MAIN = 3'd0,
    OP_WRITE_OVL  = 3'd1,
    OP_START      = 3'd2,
    OP_STOP       = 3'd3,
    OP_TICK       = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_SIZE    = 3'd0,
    REG_LOOP_START     = 3'd1,
    REG_LOOP_LENGTH    = 3'd2,
    REG_VOLUME         = 3'd3,
    REG_TICK_PERIOD    = 3'd4,
    REG_LEFT_SIDE      = 3'd5,
    REG_OVERLAY_OFFSET = 3'd6,
    REG_OVERLAY_LENGTH = 3'd7
  } cfg_reg_t;

  // Store write command from the control logic.
  typedef struct packed {
    logic              main_we;
    logic              ovl_we;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  // Store read command: cursor position in the main store, position within
  // the overlay window, and which of the two bytes to hand back.
  typedef struct packed {
    logic             rd_en;
    logic             use_overlay;
    logic [CUR_W-1:0] main_pos;
    logic [CUR_W-1:0] ovl_pos;
  } store_rd_t;

endpackage

`default_nettype wire

/* rtl/core/spc_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface spc_in_if;
  logic                          valid;
  logic                          ready;
  logic [spc_pkg::OP_W-1:0]      operation;
  logic [spc_pkg::ADDR_W-1:0]    address;
  logic [spc_pkg::BYTE_W-1:0]    write_data;

  modport source (output valid, operation, address, write_data, input ready);
  modport sink   (input valid, operation, address, write_data, output ready);
endinterface

`default_nettype wire

/* rtl/core/spc_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface spc_out_if;
  logic                          valid;
  logic                          ready;
  logic [spc_pkg::BYTE_W-1:0]    left_sample;
  logic [spc_pkg::BYTE_W-1:0]    right_sample;
  logic                          is_playing;

  modport source (output valid, left_sample, right_sample, is_playing, input ready);
  modport sink   (input valid, left_sample, right_sample, is_playing, output ready);
endinterface

`default_nettype wire

/* rtl/core/spc_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface spc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [spc_pkg::CFG_IDX_W-1:0]     index;
  logic [spc_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/spc_store.sv */
`timescale 1ns / 1ps
`default_nettype none

// Main sample memory and overlay memory, one write and one registered read
// each. Positions wrap modulo the (power-of-two) depths.
module spc_store #(
  parameter int SAMPLE_DEPTH  = spc_pkg::SAMPLE_DEPTH_DEF,
  parameter int OVERLAY_DEPTH = spc_pkg::OVERLAY_DEPTH_DEF
) (
  input  wire                              clk,
  input  wire spc_pkg::store_wr_t          wr,
  input  wire spc_pkg::store_rd_t          rd,
  output logic [spc_pkg::BYTE_W-1:0]       rd_byte
);

  localparam int SW = $clog2(SAMPLE_DEPTH);
  localparam int OW = $clog2(OVERLAY_DEPTH);

  logic [spc_pkg::BYTE_W-1:0] main_mem [SAMPLE_DEPTH];
  logic [spc_pkg::BYTE_W-1:0] ovl_mem  [OVERLAY_DEPTH];

  logic [31:0]                wr_wide;
  logic [31:0]                main_wide;
  logic [31:0]                ovl_wide;
  logic [SW-1:0]              main_wr_idx;
  logic [OW-1:0]              ovl_wr_idx;
  logic [SW-1:0]              main_rd_idx;
  logic [OW-1:0]              ovl_rd_idx;
  logic [spc_pkg::BYTE_W-1:0] main_q;
  logic [spc_pkg::BYTE_W-1:0] ovl_q;
  logic                       sel_q;

  assign wr_wide     = 32'(wr.address);
  assign main_wide   = 32'(rd.main_pos);
  assign ovl_wide    = 32'(rd.ovl_pos);
  assign main_wr_idx = wr_wide[SW-1:0];
  assign ovl_wr_idx  = wr_wide[OW-1:0];
  assign main_rd_idx = main_wide[SW-1:0];
  assign ovl_rd_idx  = ovl_wide[OW-1:0];

  always_ff @(posedge clk) begin
    if (wr.main_we) begin
      main_mem[main_wr_idx] <= wr.data;
    end
    if (wr.ovl_we) begin
      ovl_mem[ovl_wr_idx] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.rd_en) begin
      main_q <= main_mem[main_rd_idx];
      ovl_q  <= ovl_mem[ovl_rd_idx];
      sel_q  <= rd.use_overlay;
    end
  end

  assign rd_byte = sel_q ? ovl_q : main_q;

endmodule

`default_nettype wire

/* rtl/core/sample_playback_channel.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                     Beat when
// cfg       in   index, data                                 valid & ready
// cmd       in   operation, address, write_data              valid & ready
// result    out  left_sample, right_sample, is_playing       valid & ready
//
// One command beat is taken per clock while cmd ready is high. A tick beat's
// result passes through the synchronous store read, then the gain multiply
// and saturation into the output register.
// Reset is synchronous and clears the cursor, tick counter, playing flag and
// pipeline valids, and returns the configuration to its defaults; store
// contents are undefined until written.
// When result is stalled, one further tick waits in the read stage; cmd ready
// then drops until the output register frees.
module sample_playback_channel #(
  parameter int SAMPLE_DEPTH  = spc_pkg::SAMPLE_DEPTH_DEF,
  parameter int OVERLAY_DEPTH = spc_pkg::OVERLAY_DEPTH_DEF
) (
  input  wire       clk,
  input  wire       rst,
  spc_cfg_if.sink   cfg,
  spc_in_if.sink    cmd,
  spc_out_if.source result
);

  localparam int CW = spc_pkg::CUR_W;
  localparam int BW = spc_pkg::BYTE_W;

  // Configuration registers.
  logic [14:0] sample_size;
  logic [13:0] loop_start;
  logic [14:0] loop_length;
  logic [6:0]  volume;
  logic [15:0] tick_period;
  logic        left_side;
  logic [13:0] overlay_offset;
  logic [6:0]  overlay_length;

  // Voice state.
  logic [CW-1:0] cursor;
  logic [CW-1:0] cursor_next;
  logic [15:0]   tick_count;
  logic [15:0]   tick_count_next;
  logic          active;
  logic          active_next;

  // Pipeline: read stage and output register.
  logic s1_valid;
  logic s1_live;
  logic s1_playing;
  logic out_valid;
  logic [BW-1:0] out_left;
  logic [BW-1:0] out_right;
  logic out_playing;

  logic cmd_acc;
  logic tick_acc;
  logic out_free;

  spc_pkg::store_wr_t store_wr;
  spc_pkg::store_rd_t store_rd;
  logic [BW-1:0]      store_byte;

  // Configuration is taken at any time.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_size    <= '0;
      loop_start     <= '0;
      loop_length    <= '0;
      volume         <= '0;
      tick_period    <= 16'd1;
      left_side      <= 1'b1;
      overlay_offset <= '0;
      overlay_length <= '0;
    end else if (cfg.valid) begin
      unique case (spc_pkg::cfg_reg_t'(cfg.index))
        spc_pkg::REG_SAMPLE_SIZE:    sample_size    <= cfg.data[14:0];
        spc_pkg::REG_LOOP_START:     loop_start     <= cfg.data[13:0];
        spc_pkg::REG_LOOP_LENGTH:    loop_length    <= cfg.data[14:0];
        spc_pkg::REG_VOLUME:         volume         <= cfg.data[6:0];
        spc_pkg::REG_TICK_PERIOD:    tick_period    <= cfg.data[15:0];
        spc_pkg::REG_LEFT_SIDE:      left_side      <= cfg.data[0];
        spc_pkg::REG_OVERLAY_OFFSET: overlay_offset <= cfg.data[13:0];
        spc_pkg::REG_OVERLAY_LENGTH: overlay_length <= cfg.data[6:0];
        default: ;
      endcase
    end
  end

  // Handshake. The read stage may advance whenever the output register is
  // empty or being drained, and a new beat enters behind it in that case.
  assign out_free  = !out_valid || result.ready;
  assign cmd.ready = !s1_valid || out_free;
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign tick_acc  = cmd_acc && (cmd.operation == spc_pkg::OP_TICK);

  // Overlay window check on the current cursor. The window end is computed
  // one bit wider so that it never wraps.
  logic [CW:0] ovl_end;
  logic        in_window;

  assign ovl_end   = (CW+1)'(overlay_offset) + (CW+1)'(overlay_length);
  assign in_window = (overlay_length != '0) &&
                     ((CW+1)'(cursor) >= (CW+1)'(overlay_offset)) &&
                     ((CW+1)'(cursor) < ovl_end);

  assign store_wr.main_we = cmd_acc && (cmd.operation == spc_pkg::OP_WRITE_MAIN);
  assign store_wr.ovl_we  = cmd_acc && (cmd.operation == spc_pkg::OP_WRITE_OVL);
  assign store_wr.address = cmd.address;
  assign store_wr.data    = cmd.write_data;

  assign store_rd.rd_en       = tick_acc;
  assign store_rd.use_overlay = in_window;
  assign store_rd.main_pos    = cursor;
  assign store_rd.ovl_pos     = cursor - CW'(overlay_offset);

  spc_store #(
    .SAMPLE_DEPTH  (SAMPLE_DEPTH),
    .OVERLAY_DEPTH (OVERLAY_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr      (store_wr),
    .rd      (store_rd),
    .rd_byte (store_byte)
  );

  // Cursor advance. The byte read for this tick is at the old cursor, so the
  // new cursor, counter and playing flag are all settled at the accept edge
  // and the next tick may follow right away.
  logic [16:0]   cnt_inc;
  logic [CW-1:0] cursor_adv;
  logic [CW:0]   loop_end;

  assign cnt_inc    = 17'(tick_count) + 17'd1;
  assign cursor_adv = cursor + CW'(1);
  assign loop_end   = (CW+1)'(loop_start) + (CW+1)'(loop_length);

  always_comb begin
    cursor_next     = cursor;
    tick_count_next = tick_count;
    active_next     = active;
    if (cmd_acc) begin
      unique case (cmd.operation)
        spc_pkg::OP_START: begin
          cursor_next     = '0;
          tick_count_next = '0;
          active_next     = 1'b1;
        end
        spc_pkg::OP_STOP: begin
          active_next = 1'b0;
        end
        spc_pkg::OP_TICK: begin
          if (active) begin
            if (cnt_inc >= 17'(tick_period)) begin
              tick_count_next = 16'(cnt_inc - 17'(tick_period));
              cursor_next     = cursor_adv;
              if (loop_length > 15'(spc_pkg::MIN_LOOP)) begin
                if ((CW+1)'(cursor_adv) >= loop_end) begin
                  cursor_next = CW'(loop_start);
                end
              end else if (cursor_adv >= sample_size) begin
                active_next = 1'b0;
              end
            end else begin
              tick_count_next = cnt_inc[15:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor     <= '0;
      tick_count <= '0;
      active     <= 1'b0;
    end else begin
      cursor     <= cursor_next;
      tick_count <= tick_count_next;
      active     <= active_next;
    end
  end

  // Read stage: holds a tick whose store byte is arriving. A tick taken while
  // the voice is idle still passes through, and later shows silence.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_acc) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_live    <= active;
      s1_playing <= active_next;
    end
  end

  // Gain: center the byte, multiply by volume and divide by 64 rounding toward
  // minus infinity (an arithmetic shift), re-center and clamp to a byte.
  logic signed [8:0]  centred;
  logic signed [7:0]  vol_s;
  logic signed [16:0] prod;
  logic signed [16:0] shifted;
  logic        [10:0] level;
  logic [BW-1:0]      scaled;

  assign centred = $signed({1'b0, store_byte}) - 9'sd128;
  assign vol_s   = $signed({1'b0, volume});
  assign prod    = centred * vol_s;
  assign shifted = prod >>> spc_pkg::GAIN_SHIFT;
  assign level   = shifted[10:0] + 11'(spc_pkg::CENTRE);

  always_comb begin
    if (level[10]) begin
      scaled = '0;
    end else if (level[9:8] != 2'b00) begin
      scaled = '1;
    end else begin
      scaled = level[7:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_left    <= (s1_live && left_side)  ? scaled : BW'(spc_pkg::CENTRE);
      out_right   <= (s1_live && !left_side) ? scaled : BW'(spc_pkg::CENTRE);
      out_playing <= s1_playing;
    end
  end

  assign result.valid        = out_valid;
  assign result.left_sample  = out_left;
  assign result.right_sample = out_right;
  assign result.is_playing   = out_playing;

endmodule

`default_nettype wire
